// ----- hw/rtl/lpfr_pkg.sv -----
// Shared types and constants for the length-prefixed frame receiver.
`timescale 1ns / 1ps

package lpfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 16;
  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_BODY   = 2'd1,
    PHASE_DENY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_HEADER     = 3'd0,
    EV_BODY       = 3'd1,
    EV_CRC_GOOD   = 3'd2,
    EV_CRC_BAD    = 3'd3,
    EV_BAD_START  = 3'd4,
    EV_BAD_LENGTH = 3'd5,
    EV_DENY_DROP  = 3'd6,
    EV_IDLE       = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    REG_START_MARKER   = 2'd0,
    REG_LENGTH_MINIMUM = 2'd1,
    REG_LENGTH_MAXIMUM = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [LenW-1:0]  frame_length;
    logic [LenW-1:0]  byte_index;
    logic [ByteW-1:0] data_byte;
    event_t           event_res;
  } result_t;

endpackage

// ----- hw/rtl/lpfr_parser.sv -----
// Frame parser: header, body and deny phases with the running CRC-8.
`timescale 1ns / 1ps

module lpfr_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       command,
  input  logic [lpfr_pkg::ByteW-1:0] rx_byte,
  input  logic [lpfr_pkg::ByteW-1:0] start_marker,
  input  logic [lpfr_pkg::LenW-1:0]  length_minimum,
  input  logic [lpfr_pkg::LenW-1:0]  length_maximum,
  output lpfr_pkg::result_t          result
);

  function automatic logic [lpfr_pkg::ByteW-1:0] crc8_update(
    input logic [lpfr_pkg::ByteW-1:0] crc_in,
    input logic [lpfr_pkg::ByteW-1:0] data_in
  );
    logic [lpfr_pkg::ByteW-1:0] c;
    logic [lpfr_pkg::ByteW-1:0] d;
    logic                       fb;
    c = crc_in;
    d = data_in;
    for (int k = 0; k < lpfr_pkg::ByteW; k++) begin
      fb = c[0] ^ d[0];
      c = c >> 1;
      if (fb) begin
        c = c ^ lpfr_pkg::CrcPoly;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  lpfr_pkg::phase_t           receive_phase, receive_phase_next;
  logic [1:0]                 header_position, header_position_next;
  logic [lpfr_pkg::ByteW-1:0] length_low_byte, length_low_byte_next;
  logic [lpfr_pkg::LenW-1:0]  body_length, body_length_next;
  logic [lpfr_pkg::LenW-1:0]  body_count, body_count_next;
  logic [lpfr_pkg::ByteW-1:0] running_crc, running_crc_next;

  logic [lpfr_pkg::LenW-1:0]  assembled_len;
  logic [lpfr_pkg::LenW:0]    count_plus_one;

  assign assembled_len = {rx_byte, length_low_byte};
  assign count_plus_one = {1'b0, body_count} + {{lpfr_pkg::LenW{1'b0}}, 1'b1};

  always_comb begin
    receive_phase_next   = receive_phase;
    header_position_next = header_position;
    length_low_byte_next = length_low_byte;
    body_length_next     = body_length;
    body_count_next      = body_count;
    running_crc_next     = running_crc;
    result.event_res     = lpfr_pkg::EV_HEADER;
    result.data_byte     = rx_byte;
    result.byte_index    = '0;
    result.frame_length  = '0;

    if (command) begin
      receive_phase_next   = lpfr_pkg::PHASE_HEADER;
      header_position_next = 2'd0;
      body_count_next      = '0;
      running_crc_next     = '0;
      result.event_res     = lpfr_pkg::EV_IDLE;
      result.data_byte     = '0;
    end else begin
      case (receive_phase)
        lpfr_pkg::PHASE_DENY: begin
          result.event_res = lpfr_pkg::EV_DENY_DROP;
        end
        lpfr_pkg::PHASE_BODY: begin
          result.byte_index   = body_count;
          result.frame_length = body_length;
          if (count_plus_one >= {1'b0, body_length}) begin
            result.event_res = (rx_byte == running_crc) ? lpfr_pkg::EV_CRC_GOOD
                                                        : lpfr_pkg::EV_CRC_BAD;
            receive_phase_next   = lpfr_pkg::PHASE_HEADER;
            header_position_next = 2'd0;
            body_count_next      = '0;
            running_crc_next     = '0;
          end else begin
            running_crc_next = crc8_update(running_crc, rx_byte);
            body_count_next  = count_plus_one[lpfr_pkg::LenW-1:0];
            result.event_res = lpfr_pkg::EV_BODY;
          end
        end
        default: begin
          // The unused phase code behaves as the header phase.
          receive_phase_next = lpfr_pkg::PHASE_HEADER;
          case (header_position)
            2'd0: begin
              if (rx_byte != start_marker) begin
                receive_phase_next = lpfr_pkg::PHASE_DENY;
                result.event_res   = lpfr_pkg::EV_BAD_START;
              end else begin
                header_position_next = 2'd1;
              end
            end
            2'd1: begin
              length_low_byte_next = rx_byte;
              header_position_next = 2'd2;
            end
            default: begin
              result.frame_length  = assembled_len;
              header_position_next = 2'd0;
              if (assembled_len == '0 || assembled_len < length_minimum ||
                  assembled_len > length_maximum) begin
                receive_phase_next = lpfr_pkg::PHASE_DENY;
                result.event_res   = lpfr_pkg::EV_BAD_LENGTH;
              end else begin
                body_length_next   = assembled_len;
                body_count_next    = '0;
                running_crc_next   = '0;
                receive_phase_next = lpfr_pkg::PHASE_BODY;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_phase   <= lpfr_pkg::PHASE_HEADER;
      header_position <= 2'd0;
      length_low_byte <= '0;
      body_length     <= '0;
      body_count      <= '0;
      running_crc     <= '0;
    end else if (accept) begin
      receive_phase   <= receive_phase_next;
      header_position <= header_position_next;
      length_low_byte <= length_low_byte_next;
      body_length     <= body_length_next;
      body_count      <= body_count_next;
      running_crc     <= running_crc_next;
    end
  end

`ifndef SYNTHESIS
  a_body_count_in_range: assert property (@(posedge clk) disable iff (rst)
    receive_phase == lpfr_pkg::PHASE_BODY |-> body_count < body_length)
    else $error("body count reached the frame length while in the body phase");

  a_header_pos_only_in_header: assert property (@(posedge clk) disable iff (rst)
    header_position != 2'd0 |-> receive_phase == lpfr_pkg::PHASE_HEADER)
    else $error("header position set outside the header phase");

  a_idle_resyncs: assert property (@(posedge clk) disable iff (rst)
    accept && command |=> receive_phase == lpfr_pkg::PHASE_HEADER &&
                          header_position == 2'd0 && body_count == '0)
    else $error("line-idle beat did not return the parser to the header phase");
`endif

endmodule

// ----- hw/rtl/lpfr_skid.sv -----
// Output register with a skid stage between the parser and the result stream.
`timescale 1ns / 1ps

module lpfr_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpfr_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfr_pkg::result_t out_data
);

  logic              skid_valid;
  lpfr_pkg::result_t skid_data;
  logic              take;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!out_valid || out_ready) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    take && out_valid && !out_ready |=> skid_valid)
    else $error("beat taken during an output stall was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> !skid_valid && out_valid)
    else $error("skid stage did not move to the output register");
`endif

endmodule

// ----- hw/rtl/length_prefixed_frame_receiver_crc8_top.sv -----
// Throughput: one beat per cycle while the skid stage is empty; every input beat
// yields exactly one output beat. The input stalls whenever the skid stage is full,
// which happens only after a beat is taken while the output is stalled.
// Reset (rst, synchronous, active high) clears the parser to the header phase
// and loads start_marker 0, length_minimum 2 and length_maximum 256.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_crc8_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index, [39:24] frame_length
  output logic [2:0]  m_tuser,   // [2:0] event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [lpfr_pkg::ByteW-1:0] start_marker;
  logic [lpfr_pkg::LenW-1:0]  length_minimum;
  logic [lpfr_pkg::LenW-1:0]  length_maximum;
  logic                       accept;
  lpfr_pkg::result_t          parse_result;
  lpfr_pkg::result_t          out_result;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker   <= 8'd0;
      length_minimum <= 16'd2;
      length_maximum <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpfr_pkg::REG_START_MARKER:   start_marker   <= cfg_data[lpfr_pkg::ByteW-1:0];
        lpfr_pkg::REG_LENGTH_MINIMUM: length_minimum <= cfg_data;
        lpfr_pkg::REG_LENGTH_MAXIMUM: length_maximum <= cfg_data;
        default: ;
      endcase
    end
  end

  lpfr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (s_tuser),
    .rx_byte        (s_tdata),
    .start_marker   (start_marker),
    .length_minimum (length_minimum),
    .length_maximum (length_maximum),
    .result         (parse_result)
  );

  lpfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (parse_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {out_result.frame_length, out_result.byte_index, out_result.data_byte};
  assign m_tuser = out_result.event_res;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the length-prefixed frame receiver with CRC-8 check.
`timescale 1ns / 1ps

module testbench;

  localparam int ResetCycles = 10;
  localparam int DrainCycles = 8;
  localparam int TimeoutNs = 6_000_000;
  localparam int MaxReports = 100;
  localparam int LongFrame = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [7:0] data_byte, [23:8] byte_index, [39:24] frame_length
  logic [2:0]  m_tuser;        // [2:0] event_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [7:0]        marker_reg = 8'h00;
  logic [15:0]       len_min_reg = 16'd2;
  logic [15:0]       len_max_reg = 16'd256;
  lpfr_pkg::phase_t  rx_phase = lpfr_pkg::PHASE_HEADER;
  logic [1:0]        hdr_pos = '0;
  logic [7:0]        len_low = '0;
  logic [15:0]       body_len = '0;
  logic [15:0]       body_cnt = '0;
  logic [7:0]        body_crc = '0;

  lpfr_pkg::result_t pending_results[$];
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned crc_good_seen = 0;
  int unsigned crc_bad_seen = 0;
  int unsigned settings_used = 1;
  int unsigned fail_count = 0;

  bit          src_gaps = 1'b0;
  bit          sink_gaps = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned sink_stall = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  length_prefixed_frame_receiver_crc8_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [7:0] crc8_maxim_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ lpfr_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void deframe_rewind();
    rx_phase = lpfr_pkg::PHASE_HEADER;
    hdr_pos = 2'd0;
    body_cnt = '0;
    body_crc = '0;
  endfunction

  function automatic lpfr_pkg::result_t deframe_step(logic cmd, logic [7:0] rx);
    lpfr_pkg::result_t r;
    logic [15:0] len;
    r.event_res = lpfr_pkg::EV_IDLE;
    r.data_byte = rx;
    r.byte_index = '0;
    r.frame_length = '0;
    if (cmd) begin
      r.data_byte = '0;
      deframe_rewind();
    end else if (rx_phase == lpfr_pkg::PHASE_DENY) begin
      r.event_res = lpfr_pkg::EV_DENY_DROP;
    end else if (rx_phase == lpfr_pkg::PHASE_BODY) begin
      r.byte_index = body_cnt;
      r.frame_length = body_len;
      if ({1'b0, body_cnt} + 17'd1 >= {1'b0, body_len}) begin
        r.event_res = (rx == body_crc) ? lpfr_pkg::EV_CRC_GOOD : lpfr_pkg::EV_CRC_BAD;
        deframe_rewind();
      end else begin
        body_crc = crc8_maxim_next(body_crc, rx);
        body_cnt = body_cnt + 16'd1;
        r.event_res = lpfr_pkg::EV_BODY;
      end
    end else begin
      rx_phase = lpfr_pkg::PHASE_HEADER;
      r.event_res = lpfr_pkg::EV_HEADER;
      if (hdr_pos == 2'd0) begin
        if (rx != marker_reg) begin
          rx_phase = lpfr_pkg::PHASE_DENY;
          r.event_res = lpfr_pkg::EV_BAD_START;
        end else begin
          hdr_pos = 2'd1;
        end
      end else if (hdr_pos == 2'd1) begin
        len_low = rx;
        hdr_pos = 2'd2;
      end else begin
        len = {rx, len_low};
        r.frame_length = len;
        hdr_pos = 2'd0;
        if (len == 16'd0 || len < len_min_reg || len > len_max_reg) begin
          rx_phase = lpfr_pkg::PHASE_DENY;
          r.event_res = lpfr_pkg::EV_BAD_LENGTH;
        end else begin
          body_len = len;
          body_cnt = '0;
          body_crc = '0;
          rx_phase = lpfr_pkg::PHASE_BODY;
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned idle_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      sink_stall = idle_gap(sink_gaps);
      m_tready <= (sink_stall == 0);
      if (sink_stall > 0) sink_stall = sink_stall - 1;
    end
  end

  task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    lpfr_pkg::result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      results_seen++;
      if (m_tuser === lpfr_pkg::EV_CRC_GOOD) crc_good_seen++;
      if (m_tuser === lpfr_pkg::EV_CRC_BAD) crc_bad_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, event_res", '0, 16'(m_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.event_res) begin
          report_mismatch("event_res", 16'(want.event_res), 16'(m_tuser));
        end
        if (m_tdata[7:0] !== want.data_byte) begin
          report_mismatch("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
        end
        if (m_tdata[23:8] !== want.byte_index) begin
          report_mismatch("byte_index", want.byte_index, m_tdata[23:8]);
        end
        if (m_tdata[39:24] !== want.frame_length) begin
          report_mismatch("frame_length", want.frame_length, m_tdata[39:24]);
        end
      end
    end
  end

  task automatic send_beat(logic cmd, logic [7:0] rx);
    int unsigned gap;
    gap = idle_gap(src_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= rx;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.push_back(deframe_step(cmd, rx));
    beats_sent++;
  endtask

  task automatic send_idle();
    send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_junk(int unsigned n);
    repeat (n) send_beat(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_header(logic [7:0] first, logic [15:0] len);
    send_beat(1'b0, first);
    send_beat(1'b0, len[7:0]);
    send_beat(1'b0, len[15:8]);
  endtask

  task automatic send_body(int unsigned len, bit bad_crc);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] flip;
    crc = '0;
    flip = 8'($urandom_range(1, 255));
    for (int unsigned i = 1; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      send_beat(1'b0, b);
      crc = crc8_maxim_next(crc, b);
    end
    send_beat(1'b0, bad_crc ? (crc ^ flip) : crc);
  endtask

  task automatic send_frame(int unsigned len, bit bad_crc);
    send_header(marker_reg, 16'(len));
    send_body(len, bad_crc);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(lpfr_pkg::reg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      lpfr_pkg::REG_START_MARKER:   marker_reg = value[7:0];
      lpfr_pkg::REG_LENGTH_MINIMUM: len_min_reg = value;
      lpfr_pkg::REG_LENGTH_MAXIMUM: len_max_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [15:0] marker, logic [15:0] lo, logic [15:0] hi);
    wait_drained();
    write_reg(lpfr_pkg::REG_START_MARKER, marker);
    write_reg(lpfr_pkg::REG_LENGTH_MINIMUM, lo);
    write_reg(lpfr_pkg::REG_LENGTH_MAXIMUM, hi);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h00);
    send_idle();
    send_frame(2, 1'b0);
    send_header(8'h00, 16'd0);
    send_idle();
    send_header(8'h00, 16'd257);
    send_idle();
    send_frame(2, 1'b1);
  endtask

  task automatic test_one_byte_body();
    set_limits(16'hFFA5, 16'd1, 16'd16);
    send_header(8'hA5, 16'd1);
    send_beat(1'b0, 8'h00);
    send_header(8'hA5, 16'd1);
    send_beat(1'b0, 8'h5C);
    send_beat(1'b0, 8'hA5);
    send_idle();
    send_header(8'hA5, 16'd16);
    send_junk(3);
    send_idle();
  endtask

  task automatic test_output_hold();
    set_limits(16'h0081, 16'd4, 16'd12);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 200;
    repeat (5) send_frame($urandom_range(4, 12), 1'b0);
  endtask

  task automatic test_source_pause();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    repeat (3) send_frame($urandom_range(4, 12), $urandom_range(0, 3) == 0);
    wait_drained();
    send_idle();
    repeat (3) send_frame($urandom_range(4, 12), 1'b0);
  endtask

  task automatic test_inverted_limits();
    set_limits(16'h003C, 16'd300, 16'd100);
    send_header(8'h3C, 16'd100);
    send_junk(2);
    send_idle();
    send_header(8'h3C, 16'd200);
    send_idle();
    send_header(8'h3C, 16'd300);
    send_idle();
  endtask

  task automatic test_extreme_limits();
    set_limits(16'h00FF, 16'd1, 16'hFFFF);
    send_header(8'hFF, 16'd0);
    send_idle();
    send_frame(LongFrame, 1'b0);
    send_header(8'hFF, 16'h8000);
    send_junk(3);
    send_idle();
  endtask

  task automatic test_exact_length();
    set_limits(16'h007E, 16'd3, 16'd3);
    send_frame(3, 1'b0);
    send_header(8'h7E, 16'd2);
    send_idle();
    send_header(8'h7E, 16'd4);
    send_idle();
  endtask

  task automatic test_top_length();
    set_limits(16'h0000, 16'hFFFF, 16'hFFFF);
    send_header(8'h00, 16'hFFFE);
    send_idle();
    send_header(8'h00, 16'hFFFF);
    send_junk(2);
    send_idle();
  endtask

  task automatic test_random_traffic(int unsigned n_beats);
    int unsigned stop_at;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned len;
    stop_at = beats_sent + n_beats;
    lo = (len_min_reg == 0) ? 1 : len_min_reg;
    hi = (len_max_reg > lo + 24) ? lo + 24 : len_max_reg;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) begin
        src_gaps = 1'($urandom_range(0, 1));
        sink_gaps = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      len = (lo <= hi) ? $urandom_range(lo, hi) : lo;
      if (pick < 66) begin
        send_header(marker_reg, 16'(len));
        if (rx_phase == lpfr_pkg::PHASE_BODY && len <= LongFrame) begin
          send_body(len, pick < 8);
        end else begin
          send_junk($urandom_range(0, 3));
          send_idle();
        end
      end else if (pick < 76) begin
        if (pick < 70) begin
          send_header(marker_reg, 16'($urandom_range(0, 16'hFFFF)));
        end else begin
          send_beat(1'b0, marker_reg);
        end
        send_junk($urandom_range(0, 6));
        send_idle();
      end else if (pick < 84) begin
        send_beat(1'b0, marker_reg ^ 8'($urandom_range(1, 255)));
        send_junk($urandom_range(0, 4));
        send_idle();
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0: len = 0;
          1: len = (len_max_reg == 16'hFFFF) ? 0 : $urandom_range(len_max_reg + 1, 16'hFFFF);
          default: len = (len_min_reg > 1) ? $urandom_range(0, len_min_reg - 1) : 0;
        endcase
        send_header(marker_reg, 16'(len));
        send_junk($urandom_range(0, 3));
        send_idle();
      end else begin
        send_junk($urandom_range(0, 4));
        send_idle();
      end
    end
  endtask

  initial begin
    #(TimeoutNs);
    $display("length_prefixed_frame_receiver_crc8_top test failed");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_random_traffic(230);
    test_one_byte_body();
    test_random_traffic(190);
    test_output_hold();
    test_source_pause();
    test_exact_length();
    test_random_traffic(140);
    test_inverted_limits();
    test_random_traffic(100);
    test_extreme_limits();
    test_random_traffic(230);
    test_top_length();
    test_random_traffic(80);
    set_limits(16'($urandom_range(0, 16'hFFFF)), 16'd2, 16'd40);
    test_random_traffic(200);
    wait_drained();
    $display("Sent %0d input beats under %0d register settings; checked %0d result beats.",
             beats_sent, settings_used, results_seen);
    $display("Frames closed with a good crc: %0d, with a bad crc: %0d.",
             crc_good_seen, crc_bad_seen);
    if (fail_count == 0) begin
      $display("length_prefixed_frame_receiver_crc8_top test passed");
    end else begin
      $display("length_prefixed_frame_receiver_crc8_top test failed");
    end
    $finish;
  end

endmodule
